[rtl/trfc_pkg.sv]
// Package holding the frame layout constants and the result type of the tag reader frame checker.
`default_nettype none

package trfc_pkg;

   localparam int ByteWidth = 8;
   localparam int CardBytes = 10;
   localparam int PosWidth = 5;

   localparam logic [ByteWidth-1:0] FrameHeader = 8'h02;
   localparam logic [ByteWidth-1:0] FrameFooter = 8'h03;

   localparam logic [PosWidth-1:0] PosHeader = 5'd0;
   localparam logic [PosWidth-1:0] PosCardLast = 5'd10;
   localparam logic [PosWidth-1:0] PosCountryLast = 5'd14;
   localparam logic [PosWidth-1:0] PosBlock = 5'd15;
   localparam logic [PosWidth-1:0] PosAnimal = 5'd16;
   localparam logic [PosWidth-1:0] SumSpan = 5'd26;
   localparam logic [PosWidth-1:0] PosSum = 5'd27;
   localparam logic [PosWidth-1:0] FrameLast = 5'd29;

   typedef struct packed {
      logic [15:0] card_high;
      logic [63:0] card_low;
      logic [31:0] country;
      logic [7:0]  block_byte;
      logic [7:0]  animal_byte;
      logic [7:0]  computed_sum;
      logic        header_good;
      logic        footer_good;
      logic        sum_good;
      logic        inverse_good;
      logic        frame_good;
   } result_type;

endpackage

`default_nettype wire

[rtl/trfc_if.sv]
// Interfaces of the byte input channel and the frame result channel.
`default_nettype none

interface trfc_req_if;
   import trfc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface trfc_rsp_if;
   import trfc_pkg::*;

   logic        valid;
   logic        ready;
   logic [15:0] card_high;
   logic [63:0] card_low;
   logic [31:0] country;
   logic [7:0]  block_byte;
   logic [7:0]  animal_byte;
   logic [7:0]  computed_sum;
   logic        header_good;
   logic        footer_good;
   logic        sum_good;
   logic        inverse_good;
   logic        frame_good;

   modport source (
      output valid, input ready,
      output card_high, output card_low, output country, output block_byte,
      output animal_byte, output computed_sum, output header_good, output footer_good,
      output sum_good, output inverse_good, output frame_good
   );
   modport sink (
      input valid, output ready,
      input card_high, input card_low, input country, input block_byte,
      input animal_byte, input computed_sum, input header_good, input footer_good,
      input sum_good, input inverse_good, input frame_good
   );
endinterface

`default_nettype wire

[rtl/trfc_frame_acc.sv]
// Frame position counter, running XOR and field capture for one 30-byte frame.
`default_nettype none

module trfc_frame_acc (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          beat,
   input  wire [trfc_pkg::ByteWidth-1:0] data_byte,
   output logic                         frame_end,
   output trfc_pkg::result_type         result
);
   import trfc_pkg::*;

   logic [PosWidth-1:0]  pos_ff, pos_in;
   logic [ByteWidth-1:0] xor_ff, xor_in;
   logic                 header_ff, header_in;
   logic [ByteWidth-1:0] card_ff [CardBytes];
   logic [31:0]          country_ff;
   logic [ByteWidth-1:0] block_ff;
   logic [ByteWidth-1:0] animal_ff;
   logic [ByteWidth-1:0] rx_sum_ff;
   logic [ByteWidth-1:0] rx_inverse_ff;
   logic [3:0]           card_index;

   assign frame_end = beat && (pos_ff >= FrameLast);
   assign card_index = pos_ff[3:0] - 4'd1;

   always_comb begin
      pos_in = pos_ff;
      xor_in = xor_ff;
      header_in = header_ff;
      if (beat) begin
         if (pos_ff >= FrameLast) begin
            pos_in = PosHeader;
            xor_in = '0;
         end else begin
            pos_in = pos_ff + 5'd1;
            if (pos_ff == PosHeader) begin
               header_in = (data_byte == FrameHeader);
            end else if (pos_ff <= SumSpan) begin
               xor_in = xor_ff ^ data_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= PosHeader;
         xor_ff <= '0;
         header_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         xor_ff <= xor_in;
         header_ff <= header_in;
      end
   end

   always_ff @(posedge clock) begin
      if (beat && pos_ff != PosHeader) begin
         if (pos_ff <= PosCardLast) begin
            card_ff[card_index] <= data_byte;
         end else if (pos_ff <= PosCountryLast) begin
            country_ff <= {country_ff[23:0], data_byte};
         end else if (pos_ff == PosBlock) begin
            block_ff <= data_byte;
         end else if (pos_ff == PosAnimal) begin
            animal_ff <= data_byte;
         end else if (pos_ff == PosSum) begin
            rx_sum_ff <= data_byte;
         end else if (pos_ff < FrameLast) begin
            rx_inverse_ff <= data_byte;
         end
      end
   end

   always_comb begin
      result.card_high = {card_ff[0], card_ff[1]};
      result.card_low = {card_ff[2], card_ff[3], card_ff[4], card_ff[5],
                         card_ff[6], card_ff[7], card_ff[8], card_ff[9]};
      result.country = country_ff;
      result.block_byte = block_ff;
      result.animal_byte = animal_ff;
      result.computed_sum = xor_ff;
      result.header_good = header_ff;
      result.footer_good = (data_byte == FrameFooter);
      result.sum_good = (rx_sum_ff == xor_ff);
      result.inverse_good = (rx_inverse_ff == ~xor_ff);
      result.frame_good = result.header_good && result.footer_good
                          && result.sum_good && result.inverse_good;
   end

   // The position never leaves the frame.
   assert property (@(posedge clock) disable iff (reset) pos_ff <= FrameLast)
      else $error("Frame position beyond the last byte.");

   // The checksum starts afresh at every frame.
   assert property (@(posedge clock) disable iff (reset) (pos_ff == PosHeader) |-> (xor_ff == '0))
      else $error("Running XOR not cleared at frame start.");

   // A frame end returns the position to the header.
   assert property (@(posedge clock) disable iff (reset) frame_end |=> (pos_ff == PosHeader))
      else $error("Position not back at header after frame end.");

   // Every other beat advances the position by one.
   assert property (@(posedge clock) disable iff (reset)
      (beat && pos_ff < FrameLast) |=> (pos_ff == $past(pos_ff) + 5'd1))
      else $error("Position did not advance on a beat.");

endmodule

`default_nettype wire

[rtl/tag_reader_frame_checker.sv]
// Top level of the tag reader frame checker: byte channel in, one checked frame result out.
//
//   channel   direction  payload                                   beat rate
//   req_bus   in         data_byte                                 one per cycle while ready
//   rsp_bus   out        card, country, block, animal, sum, flags  one per 30 req beats
//
// Each byte is taken on a req_bus beat; the 30th byte of a frame loads the result register,
// which presents the result from the next cycle on.
// A waiting result holds req_bus.ready low only while it is stalled; when it is taken,
// a new byte is accepted in the same cycle.
// Synchronous reset clears the frame position, the checksum, the header flag and the
// result valid; frame alignment starts with the first byte after reset.
`default_nettype none

module tag_reader_frame_checker (
   input  wire          clock,
   input  wire          reset,
   trfc_req_if.sink     req_bus,
   trfc_rsp_if.source   rsp_bus
);
   import trfc_pkg::*;

   logic       beat;
   logic       frame_end;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign beat = req_bus.valid && req_bus.ready;

   trfc_frame_acc u_frame_acc (
      .clock     (clock),
      .reset     (reset),
      .beat      (beat),
      .data_byte (req_bus.data_byte),
      .frame_end (frame_end),
      .result    (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (frame_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_end) begin
         rsp_ff <= result;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.card_high = rsp_ff.card_high;
   assign rsp_bus.card_low = rsp_ff.card_low;
   assign rsp_bus.country = rsp_ff.country;
   assign rsp_bus.block_byte = rsp_ff.block_byte;
   assign rsp_bus.animal_byte = rsp_ff.animal_byte;
   assign rsp_bus.computed_sum = rsp_ff.computed_sum;
   assign rsp_bus.header_good = rsp_ff.header_good;
   assign rsp_bus.footer_good = rsp_ff.footer_good;
   assign rsp_bus.sum_good = rsp_ff.sum_good;
   assign rsp_bus.inverse_good = rsp_ff.inverse_good;
   assign rsp_bus.frame_good = rsp_ff.frame_good;

   // A completed frame always shows up as a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset) frame_end |=> rsp_valid_ff)
      else $error("Frame end did not raise the result valid.");

   // A stalled result never lets a byte through, so no result is overwritten.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |-> !frame_end)
      else $error("Result overwritten while stalled.");

   // The overall flag agrees with the four separate checks.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.frame_good == (rsp_ff.header_good && rsp_ff.footer_good
                        && rsp_ff.sum_good && rsp_ff.inverse_good)))
      else $error("Frame flag disagrees with the individual checks.");

endmodule

`default_nettype wire
